[rtl/eth_ipv4_tcp_header_parser_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the Ethernet/IPv4/TCP header parser
// Each macro expands to one labeled concurrent assertion, reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ETH_IPV4_TCP_HEADER_PARSER_MACROS_SVH
`define ETH_IPV4_TCP_HEADER_PARSER_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define EITP_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define EITP_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/eitp_pkg.sv]
// ----------------------------------------------------------------------------
// eitp_pkg
// Constants, result type and helpers for the Ethernet/IPv4/TCP header parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package eitp_pkg;

  // Result kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_CHAR   = 2'd1;
  localparam logic [1:0] KIND_TRUNC  = 2'd2;

  // Protocol constants
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [3:0]  MIN_WORDS      = 4'd5;
  localparam logic [7:0]  ETH_HDR_LEN    = 8'd14;

  // Byte offsets within the frame
  localparam logic [15:0] OFF_SRC_MAC    = 16'd6;
  localparam logic [15:0] OFF_ETYPE      = 16'd12;
  localparam logic [15:0] OFF_ETYPE_LAST = 16'd13;
  localparam logic [15:0] OFF_VER_IHL    = 16'd14;
  localparam logic [15:0] OFF_TOT_LEN    = 16'd16;
  localparam logic [15:0] OFF_TOT_LAST   = 16'd17;
  localparam logic [15:0] OFF_PROTO      = 16'd23;
  localparam logic [15:0] OFF_SRC_IP     = 16'd26;
  localparam logic [15:0] OFF_DST_IP     = 16'd30;
  localparam logic [15:0] OFF_IP_END     = 16'd34;
  localparam logic [15:0] OFF_TCP_DOFF   = 16'd12;
  localparam logic [15:0] OFF_PORTS_LEN  = 16'd4;
  localparam logic [15:0] OFF_MAX        = 16'hFFFF;

  // Display masking
  localparam logic [7:0] PRINT_LO = 8'd32;
  localparam logic [7:0] PRINT_HI = 8'd126;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] DOT_CHAR = 8'h2E;

  // Result queue
  localparam int QDEPTH = 3;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [1:0]  kind;
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] payload_length;
    logic [7:0]  shown_char;
    logic        run_last;
  } result_t;

  function automatic logic [7:0] mask_char(input logic [7:0] b);
    logic keep;
    keep = (b >= PRINT_LO && b <= PRINT_HI) || b == CHAR_LF || b == CHAR_CR;
    return keep ? b : DOT_CHAR;
  endfunction

  function automatic logic [QPTR_W-1:0] q_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

endpackage

[rtl/eth_ipv4_tcp_header_parser.sv]
// ----------------------------------------------------------------------------
// eth_ipv4_tcp_header_parser
// Streaming Ethernet/IPv4/TCP header parser with display-masked payload.
// ----------------------------------------------------------------------------
//  Channel | Ports                                   | Direction | Handshake
//  --------+-----------------------------------------+-----------+----------
//  in      | in_data_byte, in_frame_end              | input     | valid/ready
//  out     | out_kind .. out_run_last (10 fields)    | output    | valid/ready
//
//  One frame byte is taken per cycle while in_ready is high; its results land in a
//  three-entry result queue and reach the output once the older entries are gone.
//  A frame-final byte may yield two results (summary or character, then the
//  truncation record); the queue absorbs both in the same cycle.
//  in_ready is high while the queue holds at most one item, so a stalled
//  output stops the input before the queue can overflow; a drained queue never holds it back.
//  Reset (rst_n low, synchronous) empties the queue and clears the parse state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "eth_ipv4_tcp_header_parser_macros.svh"

module eth_ipv4_tcp_header_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_frame_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [47:0] out_dst_mac,
  output logic [47:0] out_src_mac,
  output logic [31:0] out_src_ip,
  output logic [31:0] out_dst_ip,
  output logic [15:0] out_src_port,
  output logic [15:0] out_dst_port,
  output logic [15:0] out_payload_length,
  output logic [7:0]  out_shown_char,
  output logic        out_run_last
);

  // --------------------------------------------------------------------------
  // Parse state
  // --------------------------------------------------------------------------
  logic [15:0] off_r, off_nxt;               // byte offset, saturating
  logic        drop_r, drop_nxt;             // rest of frame is ignored
  logic [3:0]  tcp_words_r, tcp_words_nxt;   // TCP data offset, 0 until seen
  logic [15:0] payload_left_r, payload_left_nxt;

  // Captured header fields (fully overwritten before use, no reset)
  logic [47:0] dst_mac_r, dst_mac_nxt;
  logic [47:0] src_mac_r, src_mac_nxt;
  logic [15:0] eth_type_r, eth_type_nxt;
  logic [3:0]  ip_words_r, ip_words_nxt;
  logic [15:0] ip_total_r, ip_total_nxt;
  logic [31:0] src_ip_r, src_ip_nxt;
  logic [31:0] dst_ip_r, dst_ip_nxt;
  logic [31:0] port_pair_r, port_pair_nxt;

  // Result queue
  eitp_pkg::result_t                 q_mem [eitp_pkg::QDEPTH];
  logic [eitp_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [eitp_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [eitp_pkg::QCNT_W-1:0]       count_r, count_nxt;

  logic        in_fire;
  logic        pop;
  logic        active;
  logic [7:0]  t_start;      // offset of the TCP header
  logic [7:0]  h_end;        // offset of the first payload byte
  logic [7:0]  h_last;       // offset of the last TCP header byte
  logic [6:0]  hdr_len;      // IP plus TCP header bytes
  logic [15:0] pl_total;     // payload length from the IP total length
  logic [15:0] pl_dec;
  logic [15:0] pl_after;
  logic [15:0] etype_now;
  logic        in_ports;
  logic        tcp_hit;
  logic        drop_now;
  logic        emit_ok;
  logic        hdr_hit;
  logic        char_hit;
  logic        trunc_hit;
  logic        first_v;
  logic        second_v;
  logic [1:0]  push_n;
  eitp_pkg::result_t res_a, res_b, slot0;

  assign in_ready  = count_r < eitp_pkg::QCNT_W'(2);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = count_r != '0;
  assign pop       = out_valid && out_ready;
  assign active    = !drop_r;

  // --------------------------------------------------------------------------
  // Header geometry from the captured IHL and data offset
  // --------------------------------------------------------------------------
  assign t_start  = eitp_pkg::ETH_HDR_LEN + {2'b00, ip_words_r, 2'b00};
  assign h_end    = t_start + {2'b00, tcp_words_r, 2'b00};
  assign h_last   = h_end - 8'd1;
  assign hdr_len  = {1'b0, ip_words_r, 2'b00} + {1'b0, tcp_words_r, 2'b00};
  assign pl_total = (ip_total_r > {9'b0, hdr_len}) ? ip_total_r - {9'b0, hdr_len} : '0;
  assign pl_dec   = payload_left_r - 16'd1;

  assign etype_now = {eth_type_r[7:0], in_data_byte};
  assign in_ports  = off_r >= eitp_pkg::OFF_IP_END && off_r >= {8'b0, t_start}
                     && off_r < {8'b0, t_start} + eitp_pkg::OFF_PORTS_LEN;
  assign tcp_hit   = off_r >= eitp_pkg::OFF_IP_END
                     && off_r == {8'b0, t_start} + eitp_pkg::OFF_TCP_DOFF;

  // Drop on wrong ethertype, short IHL, non-TCP protocol or short data offset
  assign drop_now = (off_r == eitp_pkg::OFF_ETYPE_LAST && etype_now != eitp_pkg::ETHERTYPE_IPV4)
                 || (off_r == eitp_pkg::OFF_VER_IHL && in_data_byte[3:0] < eitp_pkg::MIN_WORDS)
                 || (off_r == eitp_pkg::OFF_PROTO && in_data_byte != eitp_pkg::PROTO_TCP)
                 || (tcp_hit && in_data_byte[7:4] < eitp_pkg::MIN_WORDS);

  // Emission only once the TCP data offset is known
  assign emit_ok   = active && !drop_now && tcp_words_r >= eitp_pkg::MIN_WORDS;
  assign hdr_hit   = emit_ok && off_r == {8'b0, h_last};
  assign char_hit  = emit_ok && !hdr_hit && off_r >= {8'b0, h_end} && payload_left_r != '0;
  assign pl_after  = hdr_hit ? pl_total : (char_hit ? pl_dec : payload_left_r);
  assign trunc_hit = emit_ok && in_frame_end && off_r >= {8'b0, h_last} && pl_after != '0;

  assign first_v  = in_fire && (hdr_hit || char_hit);
  assign second_v = in_fire && trunc_hit;
  assign push_n   = {1'b0, first_v} + {1'b0, second_v};

  // --------------------------------------------------------------------------
  // Result records
  // --------------------------------------------------------------------------
  always_comb begin
    res_b                = '0;
    res_b.kind           = eitp_pkg::KIND_TRUNC;
    res_b.dst_mac        = dst_mac_r;
    res_b.src_mac        = src_mac_r;
    res_b.src_ip         = src_ip_r;
    res_b.dst_ip         = dst_ip_r;
    res_b.src_port       = port_pair_r[31:16];
    res_b.dst_port       = port_pair_r[15:0];
    res_b.payload_length = pl_after;

    res_a = '0;
    if (hdr_hit) begin
      res_a                = res_b;
      res_a.kind           = eitp_pkg::KIND_HEADER;
      res_a.payload_length = pl_total;
    end else begin
      res_a.kind       = eitp_pkg::KIND_CHAR;
      res_a.shown_char = eitp_pkg::mask_char(in_data_byte);
      res_a.run_last   = pl_dec == '0;
    end

    // Truncation alone takes the first slot
    slot0 = first_v ? res_a : res_b;
  end

  // --------------------------------------------------------------------------
  // Next parse state
  // --------------------------------------------------------------------------
  always_comb begin
    off_nxt          = off_r;
    drop_nxt         = drop_r;
    tcp_words_nxt    = tcp_words_r;
    payload_left_nxt = payload_left_r;
    dst_mac_nxt      = dst_mac_r;
    src_mac_nxt      = src_mac_r;
    eth_type_nxt     = eth_type_r;
    ip_words_nxt     = ip_words_r;
    ip_total_nxt     = ip_total_r;
    src_ip_nxt       = src_ip_r;
    dst_ip_nxt       = dst_ip_r;
    port_pair_nxt    = port_pair_r;

    if (in_fire && active) begin
      if (off_r < eitp_pkg::OFF_SRC_MAC) begin
        dst_mac_nxt = {dst_mac_r[39:0], in_data_byte};
      end else if (off_r < eitp_pkg::OFF_ETYPE) begin
        src_mac_nxt = {src_mac_r[39:0], in_data_byte};
      end else if (off_r < eitp_pkg::OFF_VER_IHL) begin
        eth_type_nxt = etype_now;
      end else if (off_r == eitp_pkg::OFF_VER_IHL) begin
        ip_words_nxt = in_data_byte[3:0];
      end else if (off_r == eitp_pkg::OFF_TOT_LEN || off_r == eitp_pkg::OFF_TOT_LAST) begin
        ip_total_nxt = {ip_total_r[7:0], in_data_byte};
      end else if (off_r >= eitp_pkg::OFF_SRC_IP && off_r < eitp_pkg::OFF_DST_IP) begin
        src_ip_nxt = {src_ip_r[23:0], in_data_byte};
      end else if (off_r >= eitp_pkg::OFF_DST_IP && off_r < eitp_pkg::OFF_IP_END) begin
        dst_ip_nxt = {dst_ip_r[23:0], in_data_byte};
      end

      if (in_ports) begin
        port_pair_nxt = {port_pair_r[23:0], in_data_byte};
      end
      if (tcp_hit) begin
        tcp_words_nxt = in_data_byte[7:4];
      end

      drop_nxt         = drop_now;
      payload_left_nxt = pl_after;
      if (off_r != eitp_pkg::OFF_MAX) begin
        off_nxt = off_r + 16'd1;
      end
    end

    // Frame end: return to the start of the next frame
    if (in_fire && in_frame_end) begin
      off_nxt          = '0;
      drop_nxt         = 1'b0;
      tcp_words_nxt    = '0;
      payload_left_nxt = '0;
    end
  end

  // --------------------------------------------------------------------------
  // Queue pointers
  // --------------------------------------------------------------------------
  always_comb begin
    case (push_n)
      2'd1:    wr_ptr_nxt = eitp_pkg::q_inc(wr_ptr_r);
      2'd2:    wr_ptr_nxt = eitp_pkg::q_inc(eitp_pkg::q_inc(wr_ptr_r));
      default: wr_ptr_nxt = wr_ptr_r;
    endcase
    rd_ptr_nxt = pop ? eitp_pkg::q_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + eitp_pkg::QCNT_W'(push_n) - eitp_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r          <= '0;
      drop_r         <= 1'b0;
      tcp_words_r    <= '0;
      payload_left_r <= '0;
      wr_ptr_r       <= '0;
      rd_ptr_r       <= '0;
      count_r        <= '0;
    end else begin
      off_r          <= off_nxt;
      drop_r         <= drop_nxt;
      tcp_words_r    <= tcp_words_nxt;
      payload_left_r <= payload_left_nxt;
      wr_ptr_r       <= wr_ptr_nxt;
      rd_ptr_r       <= rd_ptr_nxt;
      count_r        <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dst_mac_r   <= dst_mac_nxt;
    src_mac_r   <= src_mac_nxt;
    eth_type_r  <= eth_type_nxt;
    ip_words_r  <= ip_words_nxt;
    ip_total_r  <= ip_total_nxt;
    src_ip_r    <= src_ip_nxt;
    dst_ip_r    <= dst_ip_nxt;
    port_pair_r <= port_pair_nxt;
  end

  // Write up to two results per cycle
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      q_mem[wr_ptr_r] <= slot0;
    end
    if (push_n == 2'd2) begin
      q_mem[eitp_pkg::q_inc(wr_ptr_r)] <= res_b;
    end
  end

  // --------------------------------------------------------------------------
  // Output: head of the queue
  // --------------------------------------------------------------------------
  assign out_kind           = q_mem[rd_ptr_r].kind;
  assign out_dst_mac        = q_mem[rd_ptr_r].dst_mac;
  assign out_src_mac        = q_mem[rd_ptr_r].src_mac;
  assign out_src_ip         = q_mem[rd_ptr_r].src_ip;
  assign out_dst_ip         = q_mem[rd_ptr_r].dst_ip;
  assign out_src_port       = q_mem[rd_ptr_r].src_port;
  assign out_dst_port       = q_mem[rd_ptr_r].dst_port;
  assign out_payload_length = q_mem[rd_ptr_r].payload_length;
  assign out_shown_char     = q_mem[rd_ptr_r].shown_char;
  assign out_run_last       = q_mem[rd_ptr_r].run_last;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `EITP_ASSERT_IMP(a_two_only_at_end, clk, rst_n, in_fire && push_n == 2'd2, in_frame_end, "two results from a byte that does not end the frame")
  `EITP_ASSERT_IMP(a_drop_silent, clk, rst_n, in_fire && drop_r, push_n == 2'd0, "result emitted from a dropped frame")
  `EITP_ASSERT_NXT(a_last_char_empties, clk, rst_n, in_fire && char_hit && payload_left_r == 16'd1, payload_left_r == 16'd0, "payload count not empty after last character")
  `EITP_ASSERT_NXT(a_frame_restart, clk, rst_n, in_fire && in_frame_end, off_r == 16'd0 && !drop_r && tcp_words_r == 4'd0, "parser not restarted after frame end")

endmodule

[tb/sv/tb_eitp_result_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_eitp_result_check
// Watches both channels of the header parser. It rebuilds the parse state
// from every accepted frame byte, queues the results that byte must cause,
// and compares each accepted result against the oldest one, field by field.
// ----------------------------------------------------------------------------

module tb_eitp_result_check
  import eitp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_frame_end,
  input  logic       out_valid,
  input  logic       out_ready,
  input  result_t    out_result,
  output int         fault_count,
  output int         due_count
);

  localparam int PRINT_CAP = 100;

  // Parse state, one copy per frame
  logic [15:0] frame_pos;
  logic        dropping;
  logic [47:0] dmac;
  logic [47:0] smac;
  logic [15:0] etype_seen;
  logic [3:0]  ihl_words;
  logic [15:0] ip_len;
  logic [31:0] sip;
  logic [31:0] dip;
  logic [31:0] port_word;
  logic [3:0]  doff_words;
  logic [15:0] chars_left;

  result_t due_results[$];
  int      results_seen;

  initial begin
    fault_count = 0;
    due_count   = 0;
  end

  task automatic log_fault(input string msg);
    if (fault_count < PRINT_CAP) begin
      $display("%0t ns: result %0d: %s", $time, results_seen, msg);
    end
    fault_count++;
  endtask

  task automatic check_field(input string name, input logic [63:0] seen,
                             input logic [63:0] want);
    if (seen !== want) begin
      log_fault($sformatf("%s is 0x%0h, want 0x%0h", name, seen, want));
    end
  endtask

  task automatic clear_parse();
    frame_pos  = '0;
    dropping   = 1'b0;
    dmac       = '0;
    smac       = '0;
    etype_seen = '0;
    ihl_words  = '0;
    ip_len     = '0;
    sip        = '0;
    dip        = '0;
    port_word  = '0;
    doff_words = '0;
    chars_left = '0;
  endtask

  function automatic result_t header_record(input logic [1:0] kind, input logic [15:0] len);
    result_t r;
    r = '0;
    r.kind           = kind;
    r.dst_mac        = dmac;
    r.src_mac        = smac;
    r.src_ip         = sip;
    r.dst_ip         = dip;
    r.src_port       = port_word[31:16];
    r.dst_port       = port_word[15:0];
    r.payload_length = len;
    return r;
  endfunction

  // Advance the parse by one byte and queue whatever it must produce.
  task automatic decode_byte(input logic [7:0] b, input logic last);
    int      off;
    int      tcp_start;
    int      hdr_end;
    int      hdr_len;
    int      pay;
    logic    keep;
    result_t r;
    if (!dropping) begin
      off       = int'(frame_pos);
      tcp_start = int'(ETH_HDR_LEN) + 4 * int'(ihl_words);
      if (off < int'(OFF_SRC_MAC)) begin
        dmac = {dmac[39:0], b};
      end else if (off < int'(OFF_ETYPE)) begin
        smac = {smac[39:0], b};
      end else if (off < int'(OFF_VER_IHL)) begin
        etype_seen = {etype_seen[7:0], b};
        if (off == int'(OFF_ETYPE_LAST) && etype_seen != ETHERTYPE_IPV4) begin
          dropping = 1'b1;
        end
      end else if (off == int'(OFF_VER_IHL)) begin
        ihl_words = b[3:0];
        if (ihl_words < MIN_WORDS) begin
          dropping = 1'b1;
        end
      end else if (off == int'(OFF_TOT_LEN) || off == int'(OFF_TOT_LAST)) begin
        ip_len = {ip_len[7:0], b};
      end else if (off == int'(OFF_PROTO)) begin
        if (b != PROTO_TCP) begin
          dropping = 1'b1;
        end
      end else if (off >= int'(OFF_SRC_IP) && off < int'(OFF_DST_IP)) begin
        sip = {sip[23:0], b};
      end else if (off >= int'(OFF_DST_IP) && off < int'(OFF_IP_END)) begin
        dip = {dip[23:0], b};
      end

      // TCP fields sit behind the IP options, so their offsets move with IHL
      if (!dropping && off >= int'(OFF_IP_END)) begin
        if (off >= tcp_start && off < tcp_start + int'(OFF_PORTS_LEN)) begin
          port_word = {port_word[23:0], b};
        end
        if (off == tcp_start + int'(OFF_TCP_DOFF)) begin
          doff_words = b[7:4];
          if (doff_words < MIN_WORDS) begin
            dropping = 1'b1;
          end
        end
      end

      if (!dropping && doff_words >= MIN_WORDS) begin
        hdr_end = tcp_start + 4 * int'(doff_words);
        if (off == hdr_end - 1) begin
          hdr_len    = 4 * (int'(ihl_words) + int'(doff_words));
          pay        = int'(ip_len) > hdr_len ? int'(ip_len) - hdr_len : 0;
          chars_left = 16'(pay);
          due_results.push_back(header_record(KIND_HEADER, chars_left));
        end else if (off >= hdr_end && chars_left != '0) begin
          keep = (b >= PRINT_LO && b <= PRINT_HI) || b == CHAR_LF || b == CHAR_CR;
          chars_left--;
          r            = '0;
          r.kind       = KIND_CHAR;
          r.shown_char = keep ? b : DOT_CHAR;
          r.run_last   = (chars_left == '0);
          due_results.push_back(r);
        end
        if (last && off >= hdr_end - 1 && chars_left != '0) begin
          due_results.push_back(header_record(KIND_TRUNC, chars_left));
        end
      end

      if (frame_pos != OFF_MAX) begin
        frame_pos++;
      end
    end
    if (last) begin
      clear_parse();
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      clear_parse();
      due_results.delete();
      results_seen = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          log_fault($sformatf("unexpected result of kind %0d", out_result.kind));
        end else begin
          want = due_results.pop_front();
          check_field("kind", out_result.kind, want.kind);
          check_field("dst_mac", out_result.dst_mac, want.dst_mac);
          check_field("src_mac", out_result.src_mac, want.src_mac);
          check_field("src_ip", out_result.src_ip, want.src_ip);
          check_field("dst_ip", out_result.dst_ip, want.dst_ip);
          check_field("src_port", out_result.src_port, want.src_port);
          check_field("dst_port", out_result.dst_port, want.dst_port);
          check_field("payload_length", out_result.payload_length, want.payload_length);
          check_field("shown_char", out_result.shown_char, want.shown_char);
          check_field("run_last", out_result.run_last, want.run_last);
        end
        results_seen++;
      end
      if (in_valid && in_ready) begin
        decode_byte(in_data_byte, in_frame_end);
      end
    end
    due_count = due_results.size();
  end

endmodule

[tb/sv/tb_eth_ipv4_tcp_header_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_eth_ipv4_tcp_header_parser
// Feeds the header parser with Ethernet frames byte by byte: hand-built frames
// for the corner cases first, then random frames, mostly well-formed TCP with
// random content, the rest broken headers, cut frames and noise. Both sides
// idle at random; a separate monitor predicts and checks every result.
// ----------------------------------------------------------------------------

module tb_eth_ipv4_tcp_header_parser;
  import eitp_pkg::*;

  localparam int ITEM_GOAL      = 1800;   // frame bytes to send in total
  localparam int DRAIN_CYCLES   = 20;
  localparam int RUN_LIMIT_NS   = 10_000_000;
  localparam int MAX_GAP        = 17;
  localparam int PROBE_COUNT    = 12;

  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_frame_end;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_kind;
  logic [47:0] out_dst_mac;
  logic [47:0] out_src_mac;
  logic [31:0] out_src_ip;
  logic [31:0] out_dst_ip;
  logic [15:0] out_src_port;
  logic [15:0] out_dst_port;
  logic [15:0] out_payload_length;
  logic [7:0]  out_shown_char;
  logic        out_run_last;

  int   fault_count;
  int   due_count;
  int   sent_items;           // frame bytes handed to the parser so far
  logic fast;                 // no idling on either side while set
  logic [7:0] frame_bytes[$]; // frame under construction

  eth_ipv4_tcp_header_parser u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data_byte       (in_data_byte),
    .in_frame_end       (in_frame_end),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_dst_mac        (out_dst_mac),
    .out_src_mac        (out_src_mac),
    .out_src_ip         (out_src_ip),
    .out_dst_ip         (out_dst_ip),
    .out_src_port       (out_src_port),
    .out_dst_port       (out_dst_port),
    .out_payload_length (out_payload_length),
    .out_shown_char     (out_shown_char),
    .out_run_last       (out_run_last)
  );

  tb_eitp_result_check u_result_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_frame_end (in_frame_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_result   ({out_kind, out_dst_mac, out_src_mac, out_src_ip, out_dst_ip,
                    out_src_port, out_dst_port, out_payload_length,
                    out_shown_char, out_run_last}),
    .fault_count  (fault_count),
    .due_count    (due_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Bytes around every edge of the display mask
  function automatic logic [7:0] probe_char(input int idx);
    case (idx)
      0:       return 8'h00;
      1:       return CHAR_LF - 8'd1;
      2:       return CHAR_LF;
      3:       return CHAR_LF + 8'd1;
      4:       return CHAR_CR - 8'd1;
      5:       return CHAR_CR;
      6:       return CHAR_CR + 8'd1;
      7:       return PRINT_LO - 8'd1;
      8:       return PRINT_LO;
      9:       return PRINT_HI;
      10:      return PRINT_HI + 8'd1;
      default: return 8'hFF;
    endcase
  endfunction

  // Mostly printable text, with mask edges and raw bytes mixed in
  function automatic logic [7:0] payload_byte();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom);
      1:       return probe_char($urandom_range(0, PROBE_COUNT - 1));
      default: return 8'($urandom_range(PRINT_LO, PRINT_HI));
    endcase
  endfunction

  function automatic logic [7:0] addr_byte(input fill_t fill);
    case (fill)
      FILL_ZERO: return 8'h00;
      FILL_ONES: return 8'hFF;
      default:   return 8'($urandom);
    endcase
  endfunction

  // Assemble one frame: Ethernet, IPv4 with options, TCP with options,
  // payload and trailing padding. len_adj skews the IP total length away
  // from the true size; the result is clamped to 16 bits.
  task automatic build_frame(input logic [15:0] etype, input logic [7:0] proto,
                             input logic [3:0] ihl, input logic [3:0] doff,
                             input int pay_n, input int len_adj, input int pad_n,
                             input fill_t fill);
    int tot;
    frame_bytes.delete();
    repeat (12) frame_bytes.push_back(addr_byte(fill));
    frame_bytes.push_back(etype[15:8]);
    frame_bytes.push_back(etype[7:0]);
    tot = 4 * int'(ihl) + 4 * int'(doff) + pay_n + len_adj;
    if (tot < 0) tot = 0;
    if (tot > 65535) tot = 65535;
    frame_bytes.push_back({4'($urandom), ihl});
    frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(8'(tot >> 8));
    frame_bytes.push_back(8'(tot));
    repeat (5) frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(proto);
    repeat (2) frame_bytes.push_back(8'($urandom));
    repeat (8) frame_bytes.push_back(addr_byte(fill));
    repeat (4 * int'(ihl) - 20) frame_bytes.push_back(8'($urandom));
    repeat (4) frame_bytes.push_back(addr_byte(fill));
    repeat (8) frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back({doff, 4'($urandom)});
    repeat (7) frame_bytes.push_back(8'($urandom));
    repeat (4 * int'(doff) - 20) frame_bytes.push_back(8'($urandom));
    repeat (pay_n) frame_bytes.push_back(payload_byte());
    repeat (pad_n) frame_bytes.push_back(8'($urandom));
  endtask

  // Cut the frame short so that it ends after keep bytes
  task automatic trim_frame(input int keep);
    while (frame_bytes.size() > keep && frame_bytes.size() > 1) begin
      void'(frame_bytes.pop_back());
    end
  endtask

  // Offer one item after a random gap and return at the edge that takes it
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = fast ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_frame_end <= last;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_frame();
    sent_items += frame_bytes.size();
    foreach (frame_bytes[i]) begin
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    end
  endtask

  // Drop valid and hold off until every predicted result has come out
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (due_count == 0);
  endtask

  // Result side: after each taken result, stall for a random number of cycles
  initial begin : result_sink
    int gap;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        gap = fast ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
          @(negedge clk);
          out_ready <= 1'b0;
          repeat (gap) @(negedge clk);
          out_ready <= 1'b1;
        end
      end
    end
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    int         sel;
    int         pay_n;
    int         len_adj;
    int         pad_n;
    int         hdr_bytes;
    int         keep;
    logic [3:0] ihl;
    logic [3:0] doff;
    logic [15:0] etype;
    logic [7:0] proto;
    fill_t      fill;

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data_byte = '0;
    in_frame_end = 1'b0;
    fast         = 1'b0;
    sent_items   = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // ---- Directed frames ----------------------------------------------------
    // Bare headers, nothing to show, all-zero addresses and ports
    build_frame(ETHERTYPE_IPV4, PROTO_TCP, MIN_WORDS, MIN_WORDS, 0, 0, 0, FILL_ZERO);
    send_frame();
    // Widest headers, all-ones fields, every mask edge in the payload
    build_frame(ETHERTYPE_IPV4, PROTO_TCP, 4'd15, 4'd15, 0, PROBE_COUNT, 0, FILL_ONES);
    for (int i = 0; i < PROBE_COUNT; i++) frame_bytes.push_back(probe_char(i));
    send_frame();
    // Total length shorter than the headers: length clamps at zero, data ignored
    build_frame(ETHERTYPE_IPV4, PROTO_TCP, MIN_WORDS, MIN_WORDS, 3, -40, 0, FILL_RANDOM);
    send_frame();
    // Total length at its maximum, frame far too short: large missing count
    build_frame(ETHERTYPE_IPV4, PROTO_TCP, MIN_WORDS, 4'd6, 5, 70000, 0, FILL_RANDOM);
    send_frame();
    // Frame ends on the last header byte: summary and truncation together
    build_frame(ETHERTYPE_IPV4, PROTO_TCP, MIN_WORDS, MIN_WORDS, 6, 0, 0, FILL_RANDOM);
    trim_frame(54);
    send_frame();
    // Frame ends in the middle of the payload: character and truncation together
    build_frame(ETHERTYPE_IPV4, PROTO_TCP, 4'd6, MIN_WORDS, 8, 0, 0, FILL_RANDOM);
    trim_frame(61);
    send_frame();
    // Frame ends inside the IP header: silent
    build_frame(ETHERTYPE_IPV4, PROTO_TCP, MIN_WORDS, MIN_WORDS, 4, 0, 0, FILL_RANDOM);
    trim_frame(30);
    send_frame();
    // Padding after the payload is ignored
    build_frame(ETHERTYPE_IPV4, PROTO_TCP, MIN_WORDS, MIN_WORDS, 4, 0, 6, FILL_RANDOM);
    send_frame();
    // Exactly one payload character, which is also the last
    build_frame(ETHERTYPE_IPV4, PROTO_TCP, MIN_WORDS, MIN_WORDS, 1, 0, 0, FILL_RANDOM);
    send_frame();
    // Not IPv4, near misses included
    build_frame(16'h0806, PROTO_TCP, MIN_WORDS, MIN_WORDS, 4, 0, 0, FILL_RANDOM);
    send_frame();
    build_frame(16'h0801, PROTO_TCP, MIN_WORDS, MIN_WORDS, 4, 0, 0, FILL_RANDOM);
    send_frame();
    // Not TCP
    build_frame(ETHERTYPE_IPV4, 8'd17, MIN_WORDS, MIN_WORDS, 4, 0, 0, FILL_RANDOM);
    send_frame();
    // Short IP header, zero and one below the minimum
    build_frame(ETHERTYPE_IPV4, PROTO_TCP, 4'd0, MIN_WORDS, 4, 0, 0, FILL_RANDOM);
    send_frame();
    build_frame(ETHERTYPE_IPV4, PROTO_TCP, MIN_WORDS - 4'd1, MIN_WORDS, 4, 0, 0, FILL_RANDOM);
    send_frame();
    // Short TCP header, zero and one below the minimum
    build_frame(ETHERTYPE_IPV4, PROTO_TCP, MIN_WORDS, 4'd0, 4, 0, 0, FILL_RANDOM);
    send_frame();
    build_frame(ETHERTYPE_IPV4, PROTO_TCP, MIN_WORDS, MIN_WORDS - 4'd1, 4, 0, 0, FILL_RANDOM);
    send_frame();
    // A frame of a single byte
    frame_bytes.delete();
    frame_bytes.push_back(8'($urandom));
    send_frame();
    // Let everything come out before the random part starts
    drain_results();

    // ---- Random frames ------------------------------------------------------
    while (sent_items < ITEM_GOAL) begin
      fast = ($urandom_range(0, 4) == 0);

      sel   = $urandom_range(0, 99);
      etype = ETHERTYPE_IPV4;
      proto = PROTO_TCP;
      ihl   = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 15)) : MIN_WORDS;
      doff  = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 15)) : MIN_WORDS;
      pay_n = $urandom_range(0, 24);
      pad_n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
      case ($urandom_range(0, 9))
        0:       len_adj = -$urandom_range(1, 60);
        1:       len_adj = $urandom_range(1, 30);
        2:       len_adj = 70000;
        default: len_adj = 0;
      endcase
      case ($urandom_range(0, 9))
        0:       fill = FILL_ONES;
        1:       fill = FILL_ZERO;
        default: fill = FILL_RANDOM;
      endcase

      // Break one header field in about a quarter of the frames
      if (sel >= 62 && sel < 70) begin
        etype = ($urandom_range(0, 1) == 0) ? 16'($urandom)
                                            : ETHERTYPE_IPV4 ^ (16'd1 << $urandom_range(0, 15));
        if (etype == ETHERTYPE_IPV4) etype = etype ^ 16'h8000;
      end else if (sel >= 70 && sel < 77) begin
        proto = PROTO_TCP ^ (8'd1 << $urandom_range(0, 7));
      end else if (sel >= 77 && sel < 83) begin
        ihl = 4'($urandom_range(0, 4));
      end else if (sel >= 83 && sel < 89) begin
        doff = 4'($urandom_range(0, 4));
      end

      build_frame(etype, proto, ihl, doff, pay_n, len_adj, pad_n, fill);

      if (sel >= 89) begin
        // Pure noise of random length
        frame_bytes.delete();
        repeat ($urandom_range(1, 40)) frame_bytes.push_back(8'($urandom));
      end else if ($urandom_range(0, 6) == 0) begin
        // Cut short, often right around the end of the TCP header
        hdr_bytes = 14 + 4 * int'(ihl) + 4 * int'(doff);
        keep = ($urandom_range(0, 1) == 0) ? hdr_bytes + $urandom_range(0, 3)
                                           : $urandom_range(1, frame_bytes.size());
        trim_frame(keep);
      end

      send_frame();

      // Now and then hold the input until the output has caught up
      if ($urandom_range(0, 7) == 0) drain_results();
    end

    // ---- Wrap up ------------------------------------------------------------
    fast = 1'b0;
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
